@@ src/ebrce_pkg.sv @@
// ----------------------------------------------------------------------------
// ebrce_pkg
// Shared types and constants for the eight-bit risc execute core: command and
// opcode codes, the accepted transaction payload and the execute result bundle.
// ----------------------------------------------------------------------------
package ebrce_pkg;

  // machine widths
  localparam int DATA_W        = 8;
  localparam int ADDR_W        = 8;
  localparam int INSTR_W       = 16;
  localparam int NUM_REGS      = 16;
  localparam int REG_AW        = $clog2(NUM_REGS);
  localparam int MEM_DEPTH_DEF = 256;

  // transaction kind carried on tuser
  typedef enum logic [1:0] {
    CMD_EXEC   = 2'd0,
    CMD_MEM_WR = 2'd1,
    CMD_MEM_RD = 2'd2,
    CMD_IDLE   = 2'd3
  } cmd_t;

  // instruction opcodes, instr[15:12]
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_INC  = 4'd3,
    OP_AND  = 4'd4,
    OP_OR   = 4'd5,
    OP_XOR  = 4'd6,
    OP_NOT  = 4'd7,
    OP_SLLI = 4'd8,
    OP_SRLI = 4'd9,
    OP_LI   = 4'd10,
    OP_LD   = 4'd11,
    OP_ST   = 4'd12,
    OP_JMP  = 4'd13,
    OP_BEQZ = 4'd14,
    OP_HLT  = 4'd15
  } op_t;

  // one accepted input transaction
  typedef struct packed {
    cmd_t                cmd;
    logic [INSTR_W-1:0]  instr;
    logic [ADDR_W-1:0]   mem_addr;
    logic [DATA_W-1:0]   mem_wdata;
  } item_t;

  // what the execute stage asks of the state
  typedef struct packed {
    logic                rf_we;
    logic [REG_AW-1:0]   rf_waddr;
    logic [DATA_W-1:0]   rf_wdata;
    logic                dm_we;
    logic                dm_ld;
    logic [ADDR_W-1:0]   dm_addr;
    logic [DATA_W-1:0]   dm_wdata;
    logic [ADDR_W-1:0]   pc;
    logic                halt;
  } exe_t;

endpackage

@@ src/ebrce_alu.sv @@
// ----------------------------------------------------------------------------
// ebrce_alu
// Execute logic: decodes one transaction, computes the register result, the
// data memory access, the next pc and the halt flag.
// ----------------------------------------------------------------------------
module ebrce_alu (
  input  ebrce_pkg::item_t                   item_i,
  input  logic [ebrce_pkg::DATA_W-1:0]       opa_i,   // value of rs
  input  logic [ebrce_pkg::DATA_W-1:0]       opb_i,   // value of rt, or rd for inc/st/beqz
  input  logic [ebrce_pkg::ADDR_W-1:0]       pc_i,
  input  logic                               halt_i,
  output ebrce_pkg::exe_t                    exe_o
);

  ebrce_pkg::op_t                     op;
  logic [ebrce_pkg::REG_AW-1:0]       rd;
  logic [ebrce_pkg::REG_AW-1:0]       rs;
  logic [ebrce_pkg::REG_AW-1:0]       rt;
  logic                               exec;
  logic [2*ebrce_pkg::DATA_W-1:0]     prod;
  logic [ebrce_pkg::DATA_W-1:0]       res;
  logic [ebrce_pkg::ADDR_W-1:0]       pc2;
  logic [ebrce_pkg::ADDR_W-1:0]       ea;

  // field split and shared arithmetic
  always_comb begin
    op   = ebrce_pkg::op_t'(item_i.instr[15:12]);
    rd   = item_i.instr[11:8];
    rs   = item_i.instr[7:4];
    rt   = item_i.instr[3:0];
    exec = (item_i.cmd == ebrce_pkg::CMD_EXEC) && !halt_i;
    prod = opa_i * opb_i;
    pc2  = pc_i + 8'd2;
    ea   = opa_i + {4'b0000, rt};
  end

  // register result
  always_comb begin
    case (op)
      ebrce_pkg::OP_ADD:  res = opa_i + opb_i;
      ebrce_pkg::OP_SUB:  res = opa_i - opb_i;
      ebrce_pkg::OP_MUL:  res = prod[ebrce_pkg::DATA_W-1:0];
      ebrce_pkg::OP_INC:  res = opb_i + 8'd1;
      ebrce_pkg::OP_AND:  res = opa_i & opb_i;
      ebrce_pkg::OP_OR:   res = opa_i | opb_i;
      ebrce_pkg::OP_XOR:  res = opa_i ^ opb_i;
      ebrce_pkg::OP_NOT:  res = ~opa_i;
      ebrce_pkg::OP_SLLI: res = rt[3] ? 8'd0 : (opa_i << rt[2:0]);
      ebrce_pkg::OP_SRLI: res = rt[3] ? 8'd0 : (opa_i >> rt[2:0]);
      ebrce_pkg::OP_LI:   res = {rs, rt};
      default:            res = 8'd0;
    endcase
  end

  // side effects and control flow
  always_comb begin
    exe_o          = '0;
    exe_o.rf_waddr = rd;
    exe_o.rf_wdata = res;
    exe_o.dm_addr  = item_i.mem_addr;
    exe_o.dm_wdata = item_i.mem_wdata;
    exe_o.pc       = pc_i;
    exe_o.halt     = halt_i;
    if (exec) begin
      exe_o.pc = pc2;
      case (op)
        ebrce_pkg::OP_LD: begin
          exe_o.dm_ld   = 1'b1;
          exe_o.dm_addr = ea;
        end
        ebrce_pkg::OP_ST: begin
          exe_o.dm_we    = 1'b1;
          exe_o.dm_addr  = ea;
          exe_o.dm_wdata = opb_i;
        end
        ebrce_pkg::OP_JMP: begin
          exe_o.pc = pc2 + {rd[2:0], rs, 1'b0};
        end
        ebrce_pkg::OP_BEQZ: begin
          if (opb_i == 8'd0) begin
            exe_o.pc = pc2 + {rs[2:0], rt, 1'b0};
          end
        end
        ebrce_pkg::OP_HLT: begin
          exe_o.halt = 1'b1;
        end
        default: begin
          exe_o.rf_we = 1'b1;
        end
      endcase
    end else if (item_i.cmd == ebrce_pkg::CMD_MEM_WR) begin
      exe_o.dm_we = 1'b1;
    end
  end

endmodule

@@ src/eight_bit_risc_core_execute_core.sv @@
// ----------------------------------------------------------------------------
// eight_bit_risc_core_execute_core
// Executes one instruction or one data memory access per transaction, with
// the register file and data memory in synchronous memories.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                               | tuser
//  ---------+-----------+-------------------------------------+-------------
//  in_      | input     | instr_word, mem_addr, mem_wdata     | cmd
//  out_     | output    | next_pc, read_data                  | halted
//
//  Every transaction except a load completes in the execute stage; a load then
//  moves to the load write-back stage, because its data comes out of the data
//  memory's registered read port before it is written back to the register file.
//  Results of back-to-back transactions are forwarded around both memories.
//  Reset clears pc, halt flag and the register file valid bits; the data
//  memory is not cleared.
//  A stalled out_tready holds the execute stage and then in_tready.
// ----------------------------------------------------------------------------
module eight_bit_risc_core_execute_core #(
  parameter int MEM_DEPTH = ebrce_pkg::MEM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // instr_word[15:0], mem_addr[23:16], mem_wdata[31:24]
  input  logic [1:0]  in_tuser,    // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // next_pc[7:0], read_data[15:8]
  output logic        out_tuser    // halted
);

  localparam int DM_AW = $clog2(MEM_DEPTH);
  localparam int DW    = ebrce_pkg::DATA_W;
  localparam int RAW   = ebrce_pkg::REG_AW;

  // state memories
  logic [DW-1:0]                    rf_mem [ebrce_pkg::NUM_REGS];
  logic [ebrce_pkg::NUM_REGS-1:0]   rf_vld_r;
  logic [DW-1:0]                    dm_mem [MEM_DEPTH];
  logic [DW-1:0]                    rf_qa_r;
  logic [DW-1:0]                    rf_qb_r;
  logic [DW-1:0]                    dm_q_r;

  // architectural registers
  logic [ebrce_pkg::ADDR_W-1:0]     pc_r;
  logic                             halt_r;

  // execute stage
  logic                             s1_valid_r;
  ebrce_pkg::item_t                 s1_item_r;
  logic                             rf_va_r;
  logic                             rf_vb_r;
  logic                             fwd_a_r;
  logic                             fwd_b_r;
  logic [DW-1:0]                    fwd_data_r;
  logic                             dfwd_r;
  logic [DW-1:0]                    dfwd_data_r;

  // load write-back stage
  logic                             s2_valid_r;
  logic [RAW-1:0]                   s2_rd_r;
  logic                             s2_inrange_r;

  // output register
  logic                             out_valid_r;
  logic [15:0]                      out_tdata_r;
  logic                             out_tuser_r;

  ebrce_pkg::item_t                 in_item;
  ebrce_pkg::op_t                   in_op;
  logic                             in_acc;
  logic [RAW-1:0]                   ra;
  logic [RAW-1:0]                   rb;
  logic [DW-1:0]                    opa;
  logic [DW-1:0]                    opb;
  ebrce_pkg::exe_t                  exe;
  logic                             out_free;
  logic                             s1_go;
  logic                             s1_out;
  logic                             s2_go;
  logic                             wb_en;
  logic [RAW-1:0]                   wb_addr;
  logic [DW-1:0]                    wb_data;
  logic [DW-1:0]                    ld_data;
  logic                             dm_inrange;
  logic                             dm_we;
  logic [DM_AW-1:0]                 dm_waddr;
  logic                             dm_re_acc;
  logic                             dm_re_ld;
  logic [DM_AW-1:0]                 dm_raddr;
  logic                             rd_inrange;
  logic [DW-1:0]                    rd_byte;

  // unpack the input transaction and pick register read addresses
  always_comb begin
    in_item.cmd       = ebrce_pkg::cmd_t'(in_tuser);
    in_item.instr     = in_tdata[15:0];
    in_item.mem_addr  = in_tdata[23:16];
    in_item.mem_wdata = in_tdata[31:24];
    in_op             = ebrce_pkg::op_t'(in_item.instr[15:12]);
    ra                = in_item.instr[7:4];
    if (in_op inside {ebrce_pkg::OP_INC, ebrce_pkg::OP_ST, ebrce_pkg::OP_BEQZ}) begin
      rb = in_item.instr[11:8];
    end else begin
      rb = in_item.instr[3:0];
    end
  end

  // operands: forwarded write, else memory, else reset value
  assign opa = fwd_a_r ? fwd_data_r : (rf_va_r ? rf_qa_r : '0);
  assign opb = fwd_b_r ? fwd_data_r : (rf_vb_r ? rf_qb_r : '0);

  ebrce_alu u_alu (
    .item_i (s1_item_r),
    .opa_i  (opa),
    .opb_i  (opb),
    .pc_i   (pc_r),
    .halt_i (halt_r),
    .exe_o  (exe)
  );

  // pipeline flow
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && !s2_valid_r && (exe.dm_ld || out_free);
  assign s1_out    = s1_go && !exe.dm_ld;
  assign s2_go     = s2_valid_r && out_free;
  assign in_tready = (!s1_valid_r || s1_out) && (!s2_valid_r || s2_go);
  assign in_acc    = in_tvalid && in_tready;

  // register file write port: execute result or load data
  assign ld_data = s2_inrange_r ? dm_q_r : '0;
  assign wb_en   = (s1_go && exe.rf_we) || s2_go;
  assign wb_addr = s2_go ? s2_rd_r : exe.rf_waddr;
  assign wb_data = s2_go ? ld_data : exe.rf_wdata;

  // data memory ports
  assign dm_inrange = {1'b0, exe.dm_addr} < 9'(MEM_DEPTH);
  assign dm_we      = s1_go && exe.dm_we && dm_inrange;
  assign dm_waddr   = exe.dm_addr[DM_AW-1:0];
  assign dm_re_acc  = in_acc && (in_item.cmd == ebrce_pkg::CMD_MEM_RD);
  assign dm_re_ld   = s1_go && exe.dm_ld;
  assign dm_raddr   = dm_re_ld ? exe.dm_addr[DM_AW-1:0] : in_item.mem_addr[DM_AW-1:0];

  // readback byte for a memory read transaction
  assign rd_inrange = {1'b0, s1_item_r.mem_addr} < 9'(MEM_DEPTH);
  assign rd_byte    = !rd_inrange ? '0 : (dfwd_r ? dfwd_data_r : dm_q_r);

  // register file memory
  always_ff @(posedge clk) begin
    if (wb_en) begin
      rf_mem[wb_addr] <= wb_data;
    end
    if (in_acc) begin
      rf_qa_r <= rf_mem[ra];
      rf_qb_r <= rf_mem[rb];
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= exe.dm_wdata;
    end
    if (dm_re_acc || dm_re_ld) begin
      dm_q_r <= dm_mem[dm_raddr];
    end
  end

  // execute stage payload and bypass capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r   <= in_item;
      rf_va_r     <= rf_vld_r[ra];
      rf_vb_r     <= rf_vld_r[rb];
      fwd_a_r     <= wb_en && (wb_addr == ra);
      fwd_b_r     <= wb_en && (wb_addr == rb);
      fwd_data_r  <= wb_data;
      dfwd_r      <= dm_we && (dm_waddr == in_item.mem_addr[DM_AW-1:0]);
      dfwd_data_r <= exe.dm_wdata;
    end
    if (dm_re_ld) begin
      s2_rd_r      <= exe.rf_waddr;
      s2_inrange_r <= dm_inrange;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      rf_vld_r    <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (dm_re_ld) begin
        s2_valid_r <= 1'b1;
      end else if (s2_go) begin
        s2_valid_r <= 1'b0;
      end
      if (s1_out || s2_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        pc_r   <= exe.pc;
        halt_r <= exe.halt;
      end
      if (wb_en) begin
        rf_vld_r[wb_addr] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_tdata_r <= {8'd0, pc_r};
      out_tuser_r <= halt_r;
    end else if (s1_out) begin
      if (s1_item_r.cmd == ebrce_pkg::CMD_MEM_RD) begin
        out_tdata_r <= {rd_byte, exe.pc};
      end else begin
        out_tdata_r <= {8'd0, exe.pc};
      end
      out_tuser_r <= exe.halt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef NO_ASSERTIONS
  // a load and a younger transaction never sit in the pipe together
  a_single_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && s2_valid_r))
    else $error("execute and load stages both occupied");

  // a load in execute holds off the next transaction
  a_load_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && exe.dm_ld) |-> !in_tready)
    else $error("transaction accepted behind a load in execute");

  // a result is only loaded when the output register is free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_out || s2_go) |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  // the data memory read port serves one requester at a time
  a_dm_read_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(dm_re_acc && dm_re_ld))
    else $error("data memory read port collision");

  // once halted the machine stays halted
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared");
`endif

endmodule

@@ sim/ebrce_exec_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebrce_exec_checker
// Watches both stream channels of the execute core. Every accepted input
// transaction is run through a behavioral copy of the machine (registers,
// data memory, pc, halt flag) and the resulting state is queued. Every
// accepted output transaction is compared field by field with the oldest
// queued state.
// ----------------------------------------------------------------------------
module ebrce_exec_checker #(
  parameter int MEM_DEPTH = ebrce_pkg::MEM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,    // instr_word[15:0], mem_addr[23:16], mem_wdata[31:24]
  input  logic [1:0]  in_tuser,    // cmd[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // next_pc[7:0], read_data[15:8]
  input  logic        out_tuser,   // halted
  output int          mismatches,
  output int          outstanding
);

  // machine state visible after one transaction
  typedef struct packed {
    logic [7:0] pc;
    logic       halted;
    logic [7:0] rdata;
  } mach_out_t;

  logic [7:0] arch_regs [ebrce_pkg::NUM_REGS];
  logic [7:0] dmem_img  [MEM_DEPTH];
  logic [7:0] arch_pc;
  logic       arch_halt;
  mach_out_t  state_after_q [$];
  int         result_idx;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns  result %0d: %s", $time, result_idx, what);
  endtask

  // apply one transaction to the machine copy and return the visible state
  task automatic step_machine(input ebrce_pkg::cmd_t cmd, input logic [15:0] word,
                              input logic [7:0] addr, input logic [7:0] wdata,
                              output mach_out_t res);
    ebrce_pkg::op_t op;
    logic [3:0]     rd, rs, rt;
    logic [7:0]     a, b, val, ea, npc;
    logic           wb;
    op  = ebrce_pkg::op_t'(word[15:12]);
    rd  = word[11:8];
    rs  = word[7:4];
    rt  = word[3:0];
    a   = arch_regs[rs];
    b   = arch_regs[rt];
    ea  = a + {4'd0, rt};
    npc = arch_pc + 8'd2;
    val = '0;
    wb  = 1'b1;
    res.rdata = '0;
    case (cmd)
      ebrce_pkg::CMD_EXEC: begin
        // a halted machine ignores instructions
        if (!arch_halt) begin
          case (op)
            ebrce_pkg::OP_ADD:  val = a + b;
            ebrce_pkg::OP_SUB:  val = a - b;
            ebrce_pkg::OP_MUL:  val = a * b;
            ebrce_pkg::OP_INC:  val = arch_regs[rd] + 8'd1;
            ebrce_pkg::OP_AND:  val = a & b;
            ebrce_pkg::OP_OR:   val = a | b;
            ebrce_pkg::OP_XOR:  val = a ^ b;
            ebrce_pkg::OP_NOT:  val = ~a;
            ebrce_pkg::OP_SLLI: val = (rt < 4'd8) ? (a << rt) : 8'd0;
            ebrce_pkg::OP_SRLI: val = (rt < 4'd8) ? (a >> rt) : 8'd0;
            ebrce_pkg::OP_LI:   val = {rs, rt};
            ebrce_pkg::OP_LD:   val = (int'(ea) < MEM_DEPTH) ? dmem_img[ea] : 8'd0;
            ebrce_pkg::OP_ST: begin
              wb = 1'b0;
              if (int'(ea) < MEM_DEPTH) dmem_img[ea] = arch_regs[rd];
            end
            // offsets are twice a signed byte, so only the low 7 bits matter mod 256
            ebrce_pkg::OP_JMP: begin
              wb  = 1'b0;
              npc = npc + {rd[2:0], rs, 1'b0};
            end
            ebrce_pkg::OP_BEQZ: begin
              wb = 1'b0;
              if (arch_regs[rd] == 8'd0) npc = npc + {rs[2:0], rt, 1'b0};
            end
            ebrce_pkg::OP_HLT: begin
              wb        = 1'b0;
              arch_halt = 1'b1;
            end
            default: ;
          endcase
          if (wb) arch_regs[rd] = val;
          arch_pc = npc;
        end
      end
      ebrce_pkg::CMD_MEM_WR: if (int'(addr) < MEM_DEPTH) dmem_img[addr] = wdata;
      ebrce_pkg::CMD_MEM_RD: res.rdata = (int'(addr) < MEM_DEPTH) ? dmem_img[addr] : 8'd0;
      default: ;
    endcase
    res.pc     = arch_pc;
    res.halted = arch_halt;
  endtask

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    mach_out_t nxt;
    mach_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < ebrce_pkg::NUM_REGS; i++) arch_regs[i] = '0;
      for (int i = 0; i < MEM_DEPTH; i++) dmem_img[i] = '0;
      arch_pc     = '0;
      arch_halt   = 1'b0;
      result_idx  = 0;
      mismatches  = 0;
      outstanding = 0;
      state_after_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        step_machine(ebrce_pkg::cmd_t'(in_tuser), in_tdata[15:0], in_tdata[23:16],
                     in_tdata[31:24], nxt);
        state_after_q.push_back(nxt);
      end
      if (out_tvalid && out_tready) begin
        if (state_after_q.size() == 0) begin
          report_mismatch("result arrived with nothing pending");
        end else begin
          want = state_after_q.pop_front();
          if (out_tdata[7:0] !== want.pc)
            report_mismatch($sformatf("next_pc %02h, want %02h", out_tdata[7:0], want.pc));
          if (out_tuser !== want.halted)
            report_mismatch($sformatf("halted %b, want %b", out_tuser, want.halted));
          if (out_tdata[15:8] !== want.rdata)
            report_mismatch($sformatf("read_data %02h, want %02h",
                                      out_tdata[15:8], want.rdata));
        end
        result_idx++;
      end
      outstanding = state_after_q.size();
    end
  end

endmodule

@@ sim/eight_bit_risc_core_execute_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_risc_core_execute_core_tb
// Drives the execute core with a data memory fill, a short directed program
// covering every opcode but halt and the corner cases, then random instruction
// and memory traffic under several sender and receiver throttling phases, then
// a halt and more traffic. Results are checked by ebrce_exec_checker.
// ----------------------------------------------------------------------------
module eight_bit_risc_core_execute_core_tb;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;    // instr_word[15:0], mem_addr[23:16], mem_wdata[31:24]
  logic [1:0]  in_tuser   = '0;    // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // next_pc[7:0], read_data[15:8]
  logic        out_tuser;          // halted

  int idle_pct  = 0;
  int stall_pct = 0;
  int mismatches;
  int outstanding;

  always #2 clk = ~clk;

  eight_bit_risc_core_execute_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ebrce_exec_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // receiver backpressure
  always @(negedge clk) out_tready = ($urandom_range(99) >= stall_pct);

  function automatic logic [15:0] encode(ebrce_pkg::op_t op, logic [3:0] rd,
                                         logic [3:0] rs, logic [3:0] rt);
    return {op, rd, rs, rt};
  endfunction

  // one input transaction; entered and left just after a falling edge
  task automatic send_item(input ebrce_pkg::cmd_t cmd, input logic [15:0] word,
                           input logic [7:0] addr, input logic [7:0] wdata);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {wdata, addr, word};
    in_tuser  = cmd;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // random traffic; some pairs clear a register and branch on it
  task automatic send_random_mix(input int count, input bit any_op);
    int             n;
    int             sel;
    logic [3:0]     zr;
    ebrce_pkg::op_t op;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        zr = 4'($urandom);
        send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_XOR, zr, zr, zr),
                  8'($urandom), 8'($urandom));
        send_item(ebrce_pkg::CMD_EXEC,
                  encode(ebrce_pkg::OP_BEQZ, zr, 4'($urandom), 4'($urandom)),
                  8'($urandom), 8'($urandom));
        n += 2;
      end else begin
        if (sel < 22) begin
          send_item(ebrce_pkg::CMD_MEM_WR, 16'($urandom), 8'($urandom), 8'($urandom));
        end else if (sel < 34) begin
          send_item(ebrce_pkg::CMD_MEM_RD, 16'($urandom), 8'($urandom), 8'($urandom));
        end else if (sel < 37) begin
          send_item(ebrce_pkg::CMD_IDLE, 16'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          op = ebrce_pkg::op_t'(4'(any_op ? $urandom_range(15) : $urandom_range(14)));
          send_item(ebrce_pkg::CMD_EXEC, {op, 12'($urandom)}, 8'($urandom), 8'($urandom));
        end
        n++;
      end
    end
  endtask

  initial begin
    int spins;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // fill data memory so that no read ever hits an unwritten byte
    for (int i = 0; i < 256; i++)
      send_item(ebrce_pkg::CMD_MEM_WR, 16'($urandom), 8'(i), 8'($urandom));

    // directed program: every opcode but halt, wrap, shift and branch corners
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_LI,   4'd1,  4'h7,  4'hF), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_LI,   4'd2,  4'h8,  4'h0), 8'hFF, 8'hFF);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_LI,   4'd15, 4'hF,  4'hF), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_ADD,  4'd3,  4'd1,  4'd2), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_SUB,  4'd5,  4'd0,  4'd15), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_MUL,  4'd6,  4'd15, 4'd15), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_INC,  4'd15, 4'd0,  4'd0), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_AND,  4'd7,  4'd1,  4'd2), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_OR,   4'd8,  4'd1,  4'd2), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_XOR,  4'd9,  4'd3,  4'd1), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_NOT,  4'd10, 4'd0,  4'd0), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_SLLI, 4'd11, 4'd10, 4'd7), 8'h00, 8'h00);
    // shifts of eight or more clear the register
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_SLLI, 4'd12, 4'd10, 4'd8), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_SRLI, 4'd13, 4'd10, 4'hF), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_SRLI, 4'd14, 4'd2,  4'd7), 8'h00, 8'h00);
    // store, load with wrapping address, load right behind a store
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_ST,   4'd10, 4'd15, 4'hF), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_LD,   4'd1,  4'd10, 4'hF), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_LD,   4'd2,  4'd15, 4'hF), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_MEM_WR, 16'hFFFF, 8'h00, 8'hFF);
    send_item(ebrce_pkg::CMD_MEM_RD, 16'h0000, 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_IDLE,   16'hFFFF, 8'hFF, 8'hFF);
    // jumps by the largest offsets, pc wraps below zero
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_JMP,  4'h8,  4'h0,  4'hF), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_JMP,  4'h7,  4'hF,  4'h0), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_BEQZ, 4'd15, 4'h8,  4'h0), 8'h00, 8'h00);
    send_item(ebrce_pkg::CMD_EXEC, encode(ebrce_pkg::OP_BEQZ, 4'd3,  4'h7,  4'hF), 8'h00, 8'h00);

    // random traffic under each throttling phase, halt kept for the end
    send_random_mix(350, 1'b0);
    idle_pct = 83;
    send_random_mix(350, 1'b0);
    idle_pct  = 0;
    stall_pct = 83;
    send_random_mix(350, 1'b0);
    idle_pct  = 16;
    stall_pct = 16;
    send_random_mix(350, 1'b0);

    // halt, then traffic against the halted machine
    send_item(ebrce_pkg::CMD_EXEC,
              encode(ebrce_pkg::OP_HLT, 4'($urandom), 4'($urandom), 4'($urandom)),
              8'($urandom), 8'($urandom));
    send_random_mix(30, 1'b1);
    in_tvalid = 1'b0;

    // drain
    spins = 0;
    while (outstanding != 0 && spins < 20000) begin
      @(negedge clk);
      spins++;
    end
    repeat (16) @(negedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
src/ebrce_pkg.sv
src/ebrce_alu.sv
src/eight_bit_risc_core_execute_core.sv
sim/ebrce_exec_checker.sv
sim/eight_bit_risc_core_execute_core_tb.sv
